### rtl/scp_pkg.sv
// ----------------------------------------------------------------------------
// scp_pkg
// Shared constants, register indexes and event codes for the scheduled pump
// controller.
// ----------------------------------------------------------------------------
package scp_pkg;

  localparam int unsigned NOW_W    = 32;
  localparam int unsigned PCT_W    = 7;
  localparam int unsigned RAIN_W   = 3;
  localparam int unsigned SCORE_W  = 12;
  localparam int unsigned HOUR_W   = 5;
  localparam int unsigned MINUTE_W = 6;
  localparam int unsigned SECS_W   = 12;
  localparam int unsigned EVENT_W  = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 12;

  // cooldown = base + step * moisture gap, at most 30000 + 300 * 127
  localparam int unsigned COOL_W   = 17;
  // run length = seconds * 1000, at most 4095000
  localparam int unsigned RUN_W    = 22;

  localparam logic [COOL_W-1:0]   COOLDOWN_BASE_MS = COOL_W'(30000);
  localparam logic [COOL_W-1:0]   COOLDOWN_STEP_MS = COOL_W'(300);
  localparam logic [RUN_W-1:0]    MS_PER_SECOND    = RUN_W'(1000);
  localparam logic [RAIN_W-1:0]   RAIN_CERTAIN     = RAIN_W'(5);
  localparam logic signed [SCORE_W-1:0] LIMIT_VEGETATIVE = SCORE_W'(550);
  localparam logic signed [SCORE_W-1:0] LIMIT_GENERATIVE = SCORE_W'(600);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MANUAL_MODE      = 3'd0,
    REG_SCHEDULE_ENABLED = 3'd1,
    REG_UPPER_MOISTURE   = 3'd2,
    REG_ON_SECONDS       = 3'd3,
    REG_START_HOUR       = 3'd4,
    REG_START_MINUTE     = 3'd5,
    REG_VEGETATIVE_PHASE = 3'd6
  } cfg_reg_t;

  typedef enum logic [EVENT_W-1:0] {
    EV_NONE    = 2'd0,
    EV_STARTED = 2'd1,
    EV_RUN_END = 2'd2,
    EV_STOPPED = 2'd3
  } event_t;

  localparam logic [PCT_W-1:0]    RST_UPPER_MOISTURE = PCT_W'(80);
  localparam logic [SECS_W-1:0]   RST_ON_SECONDS     = SECS_W'(5);
  localparam logic [HOUR_W-1:0]   RST_START_HOUR     = HOUR_W'(6);
  localparam logic [MINUTE_W-1:0] RST_START_MINUTE   = MINUTE_W'(55);

endpackage

### rtl/scheduled_pump_controller.sv
// ----------------------------------------------------------------------------
// scheduled_pump_controller
// Automatic pump control per tick, outside manual mode: forced stops, run
// timeout, and scheduled start gated by cooldown and watering score.
//
//   channel | direction | handshake              | payload
//   in      | request   | in_valid / in_ready    | now_ms soil_pct rain_level
//           |           |                        | score_tenths clock_hour/min
//   out     | result    | out_valid / out_ready  | pump_on event_code
//   cfg     | write     | cfg_wr_en              | cfg_index cfg_data
//
// One request per cycle sustained while out_ready stays high; a request is
// captured in the input register, and its result is loaded into the output
// register when the output register is empty or being taken.
// The state update is done in one pass between them, so back-to-back
// requests see each other's state. Reset is synchronous; after it the block
// accepts at once. A stalled result holds the input register once it fills.
// ----------------------------------------------------------------------------
module scheduled_pump_controller
  import scp_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,

  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [NOW_W-1:0]           in_now_ms,
  input  logic [PCT_W-1:0]           in_soil_pct,
  input  logic [RAIN_W-1:0]          in_rain_level,
  input  logic signed [SCORE_W-1:0]  in_score_tenths,
  input  logic [HOUR_W-1:0]          in_clock_hour,
  input  logic [MINUTE_W-1:0]        in_clock_minute,

  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_pump_on,
  output logic [EVENT_W-1:0]         out_event_code,

  input  logic                       cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data
);

  // configuration
  logic                manual_mode_r;
  logic                schedule_enabled_r;
  logic [PCT_W-1:0]    upper_moisture_r;
  logic [SECS_W-1:0]   on_seconds_r;
  logic [HOUR_W-1:0]   start_hour_r;
  logic [MINUTE_W-1:0] start_minute_r;
  logic                vegetative_phase_r;

  // controller state
  logic                pumping_r,      pumping_nxt;
  logic [NOW_W-1:0]    run_start_ms_r, run_start_ms_nxt;
  logic [NOW_W-1:0]    run_end_ms_r,   run_end_ms_nxt;
  logic                latch_valid_r,  latch_valid_nxt;
  logic [HOUR_W-1:0]   latch_hour_r,   latch_hour_nxt;
  logic [MINUTE_W-1:0] latch_minute_r, latch_minute_nxt;

  // input register
  logic                      s1_valid_r;
  logic [NOW_W-1:0]          s1_now_ms_r;
  logic [PCT_W-1:0]          s1_soil_pct_r;
  logic [RAIN_W-1:0]         s1_rain_level_r;
  logic signed [SCORE_W-1:0] s1_score_tenths_r;
  logic [HOUR_W-1:0]         s1_clock_hour_r;
  logic [MINUTE_W-1:0]       s1_clock_minute_r;

  // output register
  logic                out_valid_r;
  logic                out_pump_on_r;
  logic [EVENT_W-1:0]  out_event_code_r;

  logic                advance;
  logic                stop_cond;
  logic                sched_match;
  logic                sched_fires;
  logic [SECS_W-1:0]   secs_eff;
  logic [RUN_W-1:0]    run_len_ms;
  logic [PCT_W-1:0]    moisture_gap;
  logic [COOL_W-1:0]   cooldown_ms;
  logic [NOW_W-1:0]    since_start;
  logic [NOW_W-1:0]    since_end;
  logic                run_done;
  logic                cool_done;
  logic                score_ok;
  logic signed [SCORE_W-1:0] score_limit;
  event_t              event_nxt;

  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  assign out_valid      = out_valid_r;
  assign out_pump_on    = out_pump_on_r;
  assign out_event_code = out_event_code_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      manual_mode_r      <= 1'b0;
      schedule_enabled_r <= 1'b1;
      upper_moisture_r   <= RST_UPPER_MOISTURE;
      on_seconds_r       <= RST_ON_SECONDS;
      start_hour_r       <= RST_START_HOUR;
      start_minute_r     <= RST_START_MINUTE;
      vegetative_phase_r <= 1'b1;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_MANUAL_MODE:      manual_mode_r      <= cfg_data[0];
        REG_SCHEDULE_ENABLED: schedule_enabled_r <= cfg_data[0];
        REG_UPPER_MOISTURE:   upper_moisture_r   <= cfg_data[PCT_W-1:0];
        REG_ON_SECONDS:       on_seconds_r       <= cfg_data[SECS_W-1:0];
        REG_START_HOUR:       start_hour_r       <= cfg_data[HOUR_W-1:0];
        REG_START_MINUTE:     start_minute_r     <= cfg_data[MINUTE_W-1:0];
        REG_VEGETATIVE_PHASE: vegetative_phase_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // datapath
  assign stop_cond = !schedule_enabled_r || (s1_rain_level_r >= RAIN_CERTAIN) ||
                     (s1_soil_pct_r >= upper_moisture_r);

  assign secs_eff   = (on_seconds_r == '0) ? SECS_W'(1) : on_seconds_r;
  assign run_len_ms = RUN_W'(secs_eff) * MS_PER_SECOND;
  assign since_start = s1_now_ms_r - run_start_ms_r;
  assign run_done    = since_start >= NOW_W'(run_len_ms);

  assign moisture_gap = upper_moisture_r - s1_soil_pct_r;
  assign cooldown_ms  = COOLDOWN_BASE_MS + COOLDOWN_STEP_MS * COOL_W'(moisture_gap);
  assign since_end    = s1_now_ms_r - run_end_ms_r;
  assign cool_done    = since_end > NOW_W'(cooldown_ms);

  assign score_limit = vegetative_phase_r ? LIMIT_VEGETATIVE : LIMIT_GENERATIVE;
  assign score_ok    = s1_score_tenths_r > score_limit;

  assign sched_match = (s1_clock_hour_r == start_hour_r) &&
                       (s1_clock_minute_r == start_minute_r);
  assign sched_fires = sched_match &&
                       !(latch_valid_r && (latch_hour_r == s1_clock_hour_r) &&
                         (latch_minute_r == s1_clock_minute_r));

  always_comb begin
    pumping_nxt      = pumping_r;
    run_start_ms_nxt = run_start_ms_r;
    run_end_ms_nxt   = run_end_ms_r;
    latch_valid_nxt  = latch_valid_r;
    latch_hour_nxt   = latch_hour_r;
    latch_minute_nxt = latch_minute_r;
    event_nxt        = EV_NONE;
    if (!manual_mode_r) begin
      if (stop_cond) begin
        if (pumping_r) begin
          pumping_nxt    = 1'b0;
          run_end_ms_nxt = s1_now_ms_r;
          event_nxt      = EV_STOPPED;
        end
      end else if (pumping_r) begin
        if (run_done) begin
          pumping_nxt    = 1'b0;
          run_end_ms_nxt = s1_now_ms_r;
          event_nxt      = EV_RUN_END;
        end
      end else begin
        if (!sched_match) begin
          latch_valid_nxt  = 1'b0;
          latch_hour_nxt   = '0;
          latch_minute_nxt = '0;
        end else if (sched_fires) begin
          latch_valid_nxt  = 1'b1;
          latch_hour_nxt   = s1_clock_hour_r;
          latch_minute_nxt = s1_clock_minute_r;
          if (cool_done && score_ok) begin
            pumping_nxt      = 1'b1;
            run_start_ms_nxt = s1_now_ms_r;
            event_nxt        = EV_STARTED;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pumping_r      <= 1'b0;
      run_start_ms_r <= '0;
      run_end_ms_r   <= '0;
      latch_valid_r  <= 1'b0;
      latch_hour_r   <= '0;
      latch_minute_r <= '0;
    end else if (advance) begin
      pumping_r      <= pumping_nxt;
      run_start_ms_r <= run_start_ms_nxt;
      run_end_ms_r   <= run_end_ms_nxt;
      latch_valid_r  <= latch_valid_nxt;
      latch_hour_r   <= latch_hour_nxt;
      latch_minute_r <= latch_minute_nxt;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_now_ms_r       <= in_now_ms;
      s1_soil_pct_r     <= in_soil_pct;
      s1_rain_level_r   <= in_rain_level;
      s1_score_tenths_r <= in_score_tenths;
      s1_clock_hour_r   <= in_clock_hour;
      s1_clock_minute_r <= in_clock_minute;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_pump_on_r    <= pumping_nxt;
      out_event_code_r <= event_nxt;
    end
  end

endmodule

### rtl/scp_checker.sv
// ----------------------------------------------------------------------------
// scp_checker
// Port-level checks for the scheduled pump controller: result hold under
// stall and consistency of event codes with the delivered pump state.
// ----------------------------------------------------------------------------
module scp_checker
  import scp_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input logic                out_pump_on,
  input logic [EVENT_W-1:0]  out_event_code
);

  logic last_pump_r;
  logic out_take;

  assign out_take = out_valid && out_ready;

  // pump state of the last delivered result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_pump_r <= 1'b0;
    end else if (out_take) begin
      last_pump_r <= out_pump_on;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pump_on) &&
                                $stable(out_event_code))
    else $error("result changed while stalled");

  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_take && (out_event_code == EV_STARTED) |-> out_pump_on && !last_pump_r)
    else $error("start event without off to on transition");

  a_stop: assert property (@(posedge clk) disable iff (!rst_n)
    out_take && ((out_event_code == EV_RUN_END) || (out_event_code == EV_STOPPED))
    |-> !out_pump_on && last_pump_r)
    else $error("stop event without on to off transition");

  a_none: assert property (@(posedge clk) disable iff (!rst_n)
    out_take && (out_event_code == EV_NONE) |-> out_pump_on == last_pump_r)
    else $error("pump changed without an event");

endmodule

bind scheduled_pump_controller scp_checker u_scp_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_pump_on    (out_pump_on),
  .out_event_code (out_event_code)
);
